FILE: hdl/m3i_pkg.sv
// Shared types and constants for the 3x3 matrix inverse unit.
`default_nettype none
package m3i_pkg;

    localparam int IN_W    = 21;
    localparam int OUT_W   = 25;
    localparam int COF_W   = 43;
    localparam int PRD_W   = 42;
    localparam int DET_W   = 64;
    localparam int THR_W   = 40;
    localparam int QB      = 30;
    localparam int IN_TDW  = 192;
    localparam int OUT_TDW = 232;

    localparam logic [THR_W-1:0] THR_RESET = 40'd281474977;
    localparam logic [OUT_W-1:0] OUT_MAX   = 25'h0FF_FFFF;
    localparam logic [OUT_W-1:0] NEG_MAG   = 25'h100_0000;

    // operand indexes of the two products of each cofactor, c = x0*y0 - x1*y1
    localparam int unsigned PX0 [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int unsigned PY0 [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int unsigned PX1 [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int unsigned PY1 [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    // classified work item handed from front to back
    typedef struct packed {
        logic [8:0][COF_W-1:0] cof;
        logic [DET_W-1:0]      dmag;
        logic                  dneg;
        logic                  sing;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage
`default_nettype wire

FILE: hdl/m3i_front.sv
// Front: cofactors, determinant and singular classification pipeline.
`default_nettype none
module m3i_front import m3i_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [IN_TDW-1:0]   i_data,
    input  wire logic [THR_W-1:0]    i_thr,
    input  wire logic                i_q_full,
    output logic                     o_push,
    output t_work                    o_work
);

    logic signed [IN_W-1:0]  w_a [9];
    logic signed [PRD_W-1:0] r_p0 [9];
    logic signed [PRD_W-1:0] r_p1 [9];
    logic signed [IN_W-1:0]  r_a1 [3];
    logic signed [IN_W-1:0]  r_a2 [3];
    logic signed [COF_W-1:0] r_c2 [9];
    logic signed [COF_W-1:0] r_c3 [9];
    logic signed [DET_W-1:0] r_dp [3];
    logic signed [DET_W-1:0] w_det;
    logic [DET_W-1:0]        w_mag;
    logic [3:0]              r_v;
    logic                    w_en;
    t_work                   r_work;

    // advance the whole pipe unless the finished item cannot enter the queue
    assign w_en    = !r_v[3] || !i_q_full;
    assign o_ready = w_en;
    assign o_push  = r_v[3] && !i_q_full;
    assign o_work  = r_work;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_a[k] = $signed(i_data[k*IN_W +: IN_W]);
        end
    end

    assign w_det = r_dp[0] + r_dp[1] + r_dp[2];
    assign w_mag = w_det[DET_W-1] ? DET_W'(-w_det) : DET_W'(w_det);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // stage payloads: products, cofactors, determinant terms, classify
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 9; k++) begin
                r_p0[k] <= PRD_W'(w_a[PX0[k]] * w_a[PY0[k]]);
                r_p1[k] <= PRD_W'(w_a[PX1[k]] * w_a[PY1[k]]);
                r_c2[k] <= COF_W'(r_p0[k]) - COF_W'(r_p1[k]);
                r_c3[k] <= r_c2[k];
            end
            for (int k = 0; k < 3; k++) begin
                r_a1[k] <= w_a[k];
                r_a2[k] <= r_a1[k];
            end
            r_dp[0] <= DET_W'(r_a2[0] * r_c2[0]);
            r_dp[1] <= DET_W'(r_a2[1] * r_c2[3]);
            r_dp[2] <= DET_W'(r_a2[2] * r_c2[6]);
            for (int k = 0; k < 9; k++) begin
                r_work.cof[k] <= r_c3[k];
            end
            r_work.dmag <= w_mag;
            r_work.dneg <= w_det[DET_W-1];
            r_work.sing <= (w_mag == '0) || (w_mag < {24'd0, i_thr});
        end
    end

endmodule
`default_nettype wire

FILE: hdl/m3i_queue.sv
// Two-entry queue between the front and back.
`default_nettype none
module m3i_queue import m3i_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_work      i_work,
    input  wire logic  i_pop,
    output t_work      o_work,
    output t_qstat     o_stat
);

    t_work      r_mem [2];
    logic [1:0] r_cnt;
    logic       r_wp;
    logic       r_rp;

    assign o_work       = r_mem[r_rp];
    assign o_stat.full  = r_cnt == 2'd2;
    assign o_stat.empty = r_cnt == 2'd0;

    // track fill and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_work;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/m3i_back.sv
// Back: nine pipelined restoring dividers, rounding, saturation, output register.
`default_nettype none
module m3i_back import m3i_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_avail,
    input  t_work                     i_work,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [OUT_TDW-1:0]        o_data,
    output logic                      o_sing
);

    logic [DET_W-1:0] r_rem [0:QB][0:8];
    logic [QB-1:0]    r_q   [0:QB][0:8];
    logic [8:0]       r_big [0:QB];
    logic [8:0]       r_neg [0:QB];
    logic [DET_W-1:0] r_d   [0:QB];
    logic             r_sg  [0:QB];
    logic [QB:0]      r_bv;
    logic [DET_W:0]   w_r2  [1:QB][0:8];
    logic             w_ge  [1:QB][0:8];
    logic [QB-1:0]    w_qn  [1:QB][0:8];
    logic [COF_W-1:0] w_n   [0:8];
    logic [QB:0]      w_qr  [0:8];
    logic             w_rnd [0:8];
    logic [OUT_W-1:0] w_ent [0:8];
    logic [OUT_W-1:0] w_m   [0:8];
    logic [OUT_TDW-1:0] w_od;
    logic             r_ov;
    logic [OUT_TDW-1:0] r_od;
    logic             r_os;
    logic             w_en;

    assign w_en    = !r_ov || i_ready;
    assign o_pop   = w_en && i_avail;
    assign o_valid = r_ov;
    assign o_data  = r_od;
    assign o_sing  = r_os;

    // one quotient bit per stage for each lane
    always_comb begin
        for (int k = 1; k <= QB; k++) begin
            for (int j = 0; j < 9; j++) begin
                w_r2[k][j] = {r_rem[k-1][j], 1'b0};
                w_ge[k][j] = w_r2[k][j] >= {1'b0, r_d[k-1]};
                w_qn[k][j] = r_q[k-1][j];
                w_qn[k][j][QB-k] = w_ge[k][j];
            end
        end
        for (int j = 0; j < 9; j++) begin
            w_n[j]   = i_work.cof[j][COF_W-1] ? COF_W'(-i_work.cof[j]) : i_work.cof[j];
            w_rnd[j] = {r_rem[QB][j], 1'b0} >= {1'b0, r_d[QB]};
            w_qr[j]  = {1'b0, r_q[QB][j]} + (QB+1)'(w_rnd[j]);
            if (r_big[QB][j] || (w_qr[j] > (QB+1)'(NEG_MAG))) begin
                w_m[j] = NEG_MAG;
            end else begin
                w_m[j] = w_qr[j][OUT_W-1:0];
            end
            if (r_neg[QB][j]) begin
                w_ent[j] = ~w_m[j] + 1'b1;
            end else if (r_big[QB][j] || (w_qr[j] > (QB+1)'(OUT_MAX))) begin
                w_ent[j] = OUT_MAX;
            end else begin
                w_ent[j] = w_qr[j][OUT_W-1:0];
            end
        end
        // pack the entries, zero when singular
        w_od = '0;
        for (int j = 0; j < 9; j++) begin
            w_od[j*OUT_W +: OUT_W] = r_sg[QB] ? '0 : w_ent[j];
        end
    end

    // valid bits of the stages and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_bv <= {r_bv[QB-1:0], i_avail};
            r_ov <= r_bv[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // load: magnitude, sign, overflow check and first remainder
            r_d[0]  <= i_work.dmag;
            r_sg[0] <= i_work.sing;
            for (int j = 0; j < 9; j++) begin
                r_rem[0][j] <= {19'd0, w_n[j], 2'b00};
                r_q[0][j]   <= '0;
                r_big[0][j] <= {20'd0, w_n[j], 2'b00} >= {1'b0, i_work.dmag};
                r_neg[0][j] <= i_work.cof[j][COF_W-1] != i_work.dneg;
            end
            // divide steps
            for (int k = 1; k <= QB; k++) begin
                r_d[k]   <= r_d[k-1];
                r_sg[k]  <= r_sg[k-1];
                r_big[k] <= r_big[k-1];
                r_neg[k] <= r_neg[k-1];
                for (int j = 0; j < 9; j++) begin
                    r_rem[k][j] <= w_ge[k][j] ? DET_W'(w_r2[k][j] - {1'b0, r_d[k-1]})
                                              : w_r2[k][j][DET_W-1:0];
                    r_q[k][j]   <= w_qn[k][j];
                end
            end
            // round, saturate, zero when singular
            r_os <= r_sg[QB];
            r_od <= w_od;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/matrix3x3_inverse_unit.sv
// Top level of the 3x3 matrix inverse unit (adjugate over determinant).
//
//  channel  | ports                              | content
//  ---------+------------------------------------+------------------------------
//  in       | i_s_tvalid o_s_tready i_s_tdata    | nine Q4.16 entries, row-major
//  out      | o_m_tvalid i_m_tready o_m_tdata    | nine Q8.16 inverse entries
//           | o_m_tuser                          | is_singular
//  config   | i_cfg_we i_cfg_wdata               | singular_threshold
//
// One item per cycle sustained while the output is not stalled. Items pass through
// the determinant pipe, the two-entry queue, and the divider pipe and output
// register; the 30-stage restoring divider sets the depth.
// Reset is synchronous, clears valid bits and loads the threshold reset value.
// Output stalls freeze the divider pipe; the queue lets the front keep going.
`default_nettype none
module matrix3x3_inverse_unit import m3i_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [IN_TDW-1:0]    i_s_tdata,   // row0_col0 .. row2_col2, 21b each
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [OUT_TDW-1:0]        o_m_tdata,   // inv_row0_col0 .. inv_row2_col2, 25b
    output logic                      o_m_tuser,   // is_singular
    input  wire logic                 i_cfg_we,
    input  wire logic [THR_W-1:0]     i_cfg_wdata
);

    logic [THR_W-1:0] r_thr;
    logic             w_push;
    logic             w_pop;
    t_work            w_fw;
    t_work            w_qw;
    t_qstat           w_qs;

    // hold the threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    m3i_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_data   (i_s_tdata),
        .i_thr    (r_thr),
        .i_q_full (w_qs.full),
        .o_push   (w_push),
        .o_work   (w_fw)
    );

    m3i_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_fw),
        .i_pop   (w_pop),
        .o_work  (w_qw),
        .o_stat  (w_qs)
    );

    m3i_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (!w_qs.empty),
        .i_work  (w_qw),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_sing  (o_m_tuser)
    );

    // singular results carry all-zero entries
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("singular result with nonzero entries");

    // never push into a full queue
    a_q_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qs.full |-> !w_push)
        else $error("queue overflow");

    // never pop an empty queue
    a_q_no_udf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qs.empty |-> !w_pop)
        else $error("queue underflow");

endmodule
`default_nettype wire
